// ===== rtl/core/threshold_crossing_extremum_detector_top_defines.svh =====
// assertion macros shared by the detector checker
`ifndef THRESHOLD_CROSSING_EXTREMUM_DETECTOR_TOP_DEFINES_SVH
`define THRESHOLD_CROSSING_EXTREMUM_DETECTOR_TOP_DEFINES_SVH

// concurrent check that is off while reset is asserted
`define TCED_CHECK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("tced check failed");

// concurrent check that also runs through reset
`define TCED_CHECK_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tced reset check failed");

`endif

// ===== rtl/core/tced_pkg.sv =====
// shared types and constants of the threshold crossing / extremum detector
`timescale 1ns / 1ps

package tced_pkg;

    localparam int CHAN_W     = 4;
    localparam int POS_W      = 32;
    localparam int THR_W      = 16;
    localparam int REFR_W     = 16;
    localparam int OFFSET_W   = 31;
    localparam int ACTIVE_W   = 5;
    localparam int HIST_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [HIST_W-1:0] HIST_FULL = 2'd2;

    localparam logic DIR_RISE = 1'b0;
    localparam logic DIR_FALL = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD       = 3'd0,
        CFG_EXTREMA_MODE    = 3'd1,
        CFG_REFRACTORY      = 3'd2,
        CFG_POINT_OFFSET    = 3'd3,
        CFG_ACTIVE_CHANNELS = 3'd4
    } t_cfg_idx;

    // sign of sample minus threshold
    typedef enum logic [1:0] {
        SIGN_UNKNOWN = 2'd0,
        SIGN_ABOVE   = 2'd1,
        SIGN_BELOW   = 2'd2
    } t_sign;

    typedef struct packed {
        logic signed [THR_W-1:0] threshold;
        logic                    extrema_mode;
        logic [REFR_W-1:0]       dead_time;
        logic [OFFSET_W-1:0]     point_offset;
        logic [ACTIVE_W-1:0]     active_channels;
    } t_cfg;

    // event fields that do not depend on the sample width
    typedef struct packed {
        logic [CHAN_W-1:0] event_chan;
        logic [POS_W-1:0]  position;
        logic              direction;
    } t_evt_hdr;

endpackage

// ===== rtl/core/tced_in_if.sv =====
// sample input channel: valid, ready and one tagged sample
`timescale 1ns / 1ps

interface tced_in_if #(
    parameter int SAMPLE_BITS = 16
) ();
    import tced_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [CHAN_W-1:0]             chan;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          restart;

    modport source (output valid, chan, sample, restart, input ready);
    modport sink   (input valid, chan, sample, restart, output ready);
endinterface

// ===== rtl/core/tced_out_if.sv =====
// event output channel: valid, ready and one detected event
`timescale 1ns / 1ps

interface tced_out_if #(
    parameter int SAMPLE_BITS = 16
) ();
    import tced_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [CHAN_W-1:0]             event_chan;
    logic [POS_W-1:0]              position;
    logic                          direction;
    logic signed [SAMPLE_BITS-1:0] level;

    modport source (output valid, event_chan, position, direction, level, input ready);
    modport sink   (input valid, event_chan, position, direction, level, output ready);
endinterface

// ===== rtl/core/tced_cfg.sv =====
// configuration register file written through the plain write port
`timescale 1ns / 1ps

module tced_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tced_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tced_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output tced_pkg::t_cfg                 o_cfg
);
    import tced_pkg::*;

    t_cfg r_cfg;

    // register decode, unlisted indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold       <= '0;
            r_cfg.extrema_mode    <= 1'b0;
            r_cfg.dead_time       <= '0;
            r_cfg.point_offset    <= '0;
            r_cfg.active_channels <= ACTIVE_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_THRESHOLD:       r_cfg.threshold       <= i_cfg_data[THR_W-1:0];
                CFG_EXTREMA_MODE:    r_cfg.extrema_mode    <= i_cfg_data[0];
                CFG_REFRACTORY:      r_cfg.dead_time       <= i_cfg_data[REFR_W-1:0];
                CFG_POINT_OFFSET:    r_cfg.point_offset    <= i_cfg_data[OFFSET_W-1:0];
                CFG_ACTIVE_CHANNELS: r_cfg.active_channels <= i_cfg_data[ACTIVE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/tced_in_reg.sv =====
// input register stage holding one accepted sample
`timescale 1ns / 1ps

module tced_in_reg #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tced_in_if.sink                       s_in,
    input  logic                          i_adv,
    output logic                          o_valid,
    output logic [tced_pkg::CHAN_W-1:0]   o_chan,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    output logic                          o_restart
);
    import tced_pkg::*;

    logic                          r_valid;
    logic [CHAN_W-1:0]             r_chan;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_restart;

    // take a new sample whenever the held one moves on
    assign s_in.ready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_in.valid && s_in.ready) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    // payload capture on transfer
    always_ff @(posedge i_clk) begin
        if (s_in.valid && s_in.ready) begin
            r_chan    <= s_in.chan;
            r_sample  <= s_in.sample;
            r_restart <= s_in.restart;
        end
    end

    assign o_valid   = r_valid;
    assign o_chan    = r_chan;
    assign o_sample  = r_sample;
    assign o_restart = r_restart;

endmodule

// ===== rtl/core/tced_chan.sv =====
// per-channel detector state, point counter and event decision
`timescale 1ns / 1ps

module tced_chan #(
    parameter int CHANNELS    = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tced_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    input  logic [tced_pkg::CHAN_W-1:0]   i_chan,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_restart,
    input  logic                          i_out_free,
    output logic                          o_adv,
    output logic                          o_hit,
    output tced_pkg::t_evt_hdr            o_hdr,
    output logic signed [SAMPLE_BITS-1:0] o_level
);
    import tced_pkg::*;

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NW_CH = $clog2(CHANNELS + 1);
    localparam int NW    = (NW_CH > ACTIVE_W) ? NW_CH : ACTIVE_W;
    localparam int EW    = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 2;

    // per-channel state, entries without a valid bit read as zero
    logic [CHANNELS-1:0]           r_vld;
    t_sign                         r_ls    [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] r_prev  [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] r_older [CHANNELS];
    logic [HIST_W-1:0]             r_hc    [CHANNELS];
    logic [REFR_W-1:0]             r_rl    [CHANNELS];
    logic [POS_W-1:0]              r_pc;

    logic [CH_W-1:0]               idx;
    logic [NW-1:0]                 ac_x, nch, chan_x;
    logic                          in_range, last_chan, cur_ok;
    t_sign                         ls, sg;
    logic signed [SAMPLE_BITS-1:0] p1, p2;
    logic [HIST_W-1:0]             hc;
    logic [REFR_W-1:0]             rl;
    logic                          full;
    logic signed [EW-1:0]          s_x, p1_x, p2_x, thr_x, nthr_x, diff;
    logic [POS_W-1:0]              base;

    logic [CHANNELS-1:0]           n_vld;
    t_sign                         n_ls;
    logic signed [SAMPLE_BITS-1:0] n_prev, n_older;
    logic [HIST_W-1:0]             n_hc;
    logic [REFR_W-1:0]             n_rl;
    logic [POS_W-1:0]              n_pc;
    logic                          raw_hit, dir;
    logic [POS_W-1:0]              pos;
    logic signed [SAMPLE_BITS-1:0] lvl;

    // effective channel count and range check
    assign ac_x      = NW'(i_cfg.active_channels);
    assign nch       = (ac_x == '0) ? NW'(1) :
                       ((ac_x > NW'(CHANNELS)) ? NW'(CHANNELS) : ac_x);
    assign chan_x    = NW'(i_chan);
    assign in_range  = chan_x < nch;
    assign last_chan = chan_x == (nch - NW'(1));
    assign idx       = CH_W'(i_chan);

    // current state, restart clears it ahead of this sample
    assign cur_ok = !i_restart && r_vld[idx];
    assign ls     = cur_ok ? r_ls[idx]    : SIGN_UNKNOWN;
    assign p2     = cur_ok ? r_prev[idx]  : '0;
    assign p1     = cur_ok ? r_older[idx] : '0;
    assign hc     = cur_ok ? r_hc[idx]    : '0;
    assign rl     = cur_ok ? r_rl[idx]    : '0;
    assign full   = hc >= HIST_FULL;
    assign base   = i_restart ? POS_W'(i_cfg.point_offset) : r_pc;

    // widened compares against the threshold
    assign s_x    = EW'(i_sample);
    assign p1_x   = EW'(p1);
    assign p2_x   = EW'(p2);
    assign thr_x  = EW'($signed(i_cfg.threshold));
    assign nthr_x = -thr_x;
    assign diff   = s_x - thr_x;
    assign sg     = diff[EW-1] ? SIGN_BELOW : SIGN_ABOVE;

    // detection and next state for the addressed channel
    always_comb begin
        n_ls    = ls;
        n_prev  = p2;
        n_older = p1;
        n_hc    = hc;
        n_rl    = rl;
        raw_hit = 1'b0;
        dir     = DIR_RISE;
        pos     = base;
        lvl     = i_sample;
        if (i_cfg.extrema_mode) begin
            n_older = p2;
            n_prev  = i_sample;
            n_hc    = full ? HIST_FULL : hc + HIST_W'(1);
            if (rl != '0) begin
                n_rl = rl - REFR_W'(1);
            end else if (full) begin
                if (p2_x >= thr_x && p1_x < p2_x && s_x <= p2_x) begin
                    raw_hit = 1'b1;
                    dir     = DIR_RISE;
                end else if (p2_x <= nthr_x && p1_x > p2_x && s_x >= p2_x) begin
                    raw_hit = 1'b1;
                    dir     = DIR_FALL;
                end
                if (raw_hit) begin
                    pos  = base - POS_W'(1);
                    lvl  = p2;
                    n_rl = i_cfg.dead_time;
                end
            end
        end else begin
            if (ls == SIGN_UNKNOWN || rl != '0) begin
                if (rl != '0) begin
                    n_rl = rl - REFR_W'(1);
                end
            end else if (sg != ls) begin
                raw_hit = 1'b1;
                dir     = (sg == SIGN_BELOW) ? DIR_FALL : DIR_RISE;
                n_rl    = i_cfg.dead_time;
            end
            n_ls = sg;
        end
    end

    // next valid bits: restart drops all, the addressed entry becomes live when it is in range
    always_comb begin
        n_vld = i_restart ? '0 : r_vld;
        if (in_range) begin
            n_vld[idx] = 1'b1;
        end
    end

    assign n_pc  = (in_range && last_chan) ? base + POS_W'(1) : base;
    assign o_hit = in_range && raw_hit;
    // the sample moves on unless its event has no room
    assign o_adv = i_valid && (!o_hit || i_out_free);

    // valid bits and point counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_pc  <= '0;
        end else if (o_adv) begin
            r_vld <= n_vld;
            r_pc  <= n_pc;
        end
    end

    // state entry write-back
    always_ff @(posedge i_clk) begin
        if (o_adv && in_range) begin
            r_ls[idx]    <= n_ls;
            r_prev[idx]  <= n_prev;
            r_older[idx] <= n_older;
            r_hc[idx]    <= n_hc;
            r_rl[idx]    <= n_rl;
        end
    end

    assign o_hdr.event_chan = i_chan;
    assign o_hdr.position   = pos;
    assign o_hdr.direction  = dir;
    assign o_level          = lvl;

endmodule

// ===== rtl/core/tced_out_reg.sv =====
// result register driving the event output channel
`timescale 1ns / 1ps

module tced_out_reg #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  tced_pkg::t_evt_hdr            i_hdr,
    input  logic signed [SAMPLE_BITS-1:0] i_level,
    output logic                          o_free,
    tced_out_if.source                    m_out
);
    import tced_pkg::*;

    logic                          r_valid;
    t_evt_hdr                      r_hdr;
    logic signed [SAMPLE_BITS-1:0] r_level;

    // room for a new event when empty or being taken this cycle
    assign o_free = !r_valid || m_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (m_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // event payload capture
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_hdr   <= i_hdr;
            r_level <= i_level;
        end
    end

    assign m_out.valid      = r_valid;
    assign m_out.event_chan = r_hdr.event_chan;
    assign m_out.position   = r_hdr.position;
    assign m_out.direction  = r_hdr.direction;
    assign m_out.level      = r_level;

endmodule

// ===== rtl/core/threshold_crossing_extremum_detector_top.sv =====
// top level of the multichannel threshold crossing / extremum detector
// an accepted sample is held in the input register, and its event is then loaded into the result register
// throughput: one sample per cycle, held back only while a waiting event is not taken
// per-channel state sits in flip-flops read at the sample's channel; one pass per sample
// reset (i_rst_n low, synchronous): config to defaults, all channel state and counter cleared
`timescale 1ns / 1ps

module threshold_crossing_extremum_detector_top #(
    parameter int CHANNELS    = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tced_in_if.sink                        i_in,
    tced_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [tced_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tced_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tced_pkg::*;

    t_cfg                          cfg;
    logic                          st_valid, st_restart;
    logic [CHAN_W-1:0]             st_chan;
    logic signed [SAMPLE_BITS-1:0] st_sample;
    logic                          adv, hit, out_free;
    t_evt_hdr                      hdr;
    logic signed [SAMPLE_BITS-1:0] level;

    // configuration registers
    tced_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // input register
    tced_in_reg #(.SAMPLE_BITS(SAMPLE_BITS)) u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .s_in      (i_in),
        .i_adv     (adv),
        .o_valid   (st_valid),
        .o_chan    (st_chan),
        .o_sample  (st_sample),
        .o_restart (st_restart)
    );

    // channel state and detection
    tced_chan #(.CHANNELS(CHANNELS), .SAMPLE_BITS(SAMPLE_BITS)) u_chan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (st_valid),
        .i_chan     (st_chan),
        .i_sample   (st_sample),
        .i_restart  (st_restart),
        .i_out_free (out_free),
        .o_adv      (adv),
        .o_hit      (hit),
        .o_hdr      (hdr),
        .o_level    (level)
    );

    // result register
    tced_out_reg #(.SAMPLE_BITS(SAMPLE_BITS)) u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv && hit),
        .i_hdr   (hdr),
        .i_level (level),
        .o_free  (out_free),
        .m_out   (o_out)
    );

endmodule

// ===== rtl/core/tced_checker.sv =====
// port-level checks for the detector, bound to the top level
`timescale 1ns / 1ps
`include "threshold_crossing_extremum_detector_top_defines.svh"

module tced_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [tced_pkg::CHAN_W-1:0]    i_out_chan,
    input logic [tced_pkg::POS_W-1:0]     i_out_position,
    input logic                           i_out_direction,
    input logic signed [SAMPLE_BITS-1:0]  i_out_level,
    input logic                           i_cfg_we,
    input logic [tced_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [tced_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tced_pkg::*;

    localparam int EW = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 2;

    logic signed [THR_W-1:0]            r_thr;
    logic                               r_mode;
    logic signed [EW-1:0]               lvl_x, thr_x, nthr_x;
    logic [CHAN_W+POS_W+SAMPLE_BITS:0]  out_payload;
    logic                               out_stall, fall_ok;

    // shadow of threshold and mode seen on the write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= '0;
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_THRESHOLD) begin
                r_thr <= i_cfg_data[THR_W-1:0];
            end
            if (i_cfg_idx == CFG_EXTREMA_MODE) begin
                r_mode <= i_cfg_data[0];
            end
        end
    end

    assign lvl_x  = EW'(i_out_level);
    assign thr_x  = EW'(r_thr);
    assign nthr_x = -thr_x;

    assign out_payload = {i_out_chan, i_out_position, i_out_direction, i_out_level};
    assign out_stall   = i_out_valid && !i_out_ready;
    assign fall_ok     = r_mode ? (lvl_x <= nthr_x) : (lvl_x < thr_x);

    // stalled event holds its payload
    `TCED_CHECK(a_out_hold, i_clk, i_rst_n, out_stall |=> i_out_valid && $stable(out_payload))
    // reset empties the result register
    `TCED_CHECK_NORST(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid)
    // an empty result register never holds back input
    `TCED_CHECK(a_ready_empty, i_clk, i_rst_n, !i_out_valid |-> i_in_ready)
    // rising crossings and maxima sit at or above the threshold
    `TCED_CHECK(a_rise_level, i_clk, i_rst_n, i_out_valid && !i_out_direction |-> lvl_x >= thr_x)
    // falling crossings sit below, minima at or below minus the threshold
    `TCED_CHECK(a_fall_level, i_clk, i_rst_n, i_out_valid && i_out_direction |-> fall_ok)

endmodule

bind threshold_crossing_extremum_detector_top tced_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_tced_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_chan      (o_out.event_chan),
    .i_out_position  (o_out.position),
    .i_out_direction (o_out.direction),
    .i_out_level     (o_out.level),
    .i_cfg_we        (i_cfg_we),
    .i_cfg_idx       (i_cfg_idx),
    .i_cfg_data      (i_cfg_data)
);

// ===== tb/testbench.sv =====
// testbench for the threshold crossing / extremum detector: directed table, then random phases
`timescale 1ns / 1ps

module testbench;
    import tced_pkg::*;

    localparam int CHANNELS      = 16;
    localparam int SAMPLE_BITS   = 16;
    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 4;
    localparam int NUM_PHASES    = 10;
    localparam int PHASE_ITEMS   = 122;
    localparam int CYCLE_LIMIT   = 1000000;

    // one detected event as it leaves the block
    typedef struct packed {
        t_evt_hdr                      hdr;
        logic signed [SAMPLE_BITS-1:0] level;
    } t_det_event;

    // kinds of rows in the directed table
    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_PREDICTED,
        ROW_QUIET,
        ROW_EVENT
    } t_row_kind;

    typedef struct {
        t_row_kind  kind;
        int         a;
        int         b;
        logic       rs;
        t_det_event ev;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    tced_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
    tced_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

    threshold_crossing_extremum_detector_top #(
        .CHANNELS   (CHANNELS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .o_out     (out_ch),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // predictor copy of the registers
    int                  thr_cfg;
    bit                  mode_cfg;
    int                  refr_cfg;
    logic [OFFSET_W-1:0] offset_cfg;
    logic [ACTIVE_W-1:0] active_cfg;

    // predictor copy of the channel state
    t_sign                         chan_sign [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] hist_prev [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] hist_older[CHANNELS];
    int                            hist_fill [CHANNELS];
    int                            refr_left [CHANNELS];
    logic [POS_W-1:0]              point_ctr;

    t_det_event expected_events[$];
    t_stim_row  directed[$];
    int         fail_count = 0;
    int         cycles_run = 0;
    bit         tx_idle = 1'b0;
    bit         rx_idle = 1'b0;

    function automatic void clear_detector_state();
        for (int c = 0; c < CHANNELS; c++) begin
            chan_sign[c]  = SIGN_UNKNOWN;
            hist_prev[c]  = '0;
            hist_older[c] = '0;
            hist_fill[c]  = 0;
            refr_left[c]  = 0;
        end
    endfunction

    function automatic int live_channels();
        if (active_cfg == 0) return 1;
        if (active_cfg > CHANNELS) return CHANNELS;
        return int'(active_cfg);
    endfunction

    // advance the channel state by one sample, return 1 when it yields an event
    function automatic bit detect_event(input logic [CHAN_W-1:0] ch,
                                        input logic signed [SAMPLE_BITS-1:0] smp,
                                        input logic rs, output t_det_event ev);
        int    nch;
        int    p1, p2, p3;
        bit    full;
        bit    hit;
        t_sign sg;
        ev  = '0;
        hit = 1'b0;
        nch = live_channels();
        if (rs) begin
            clear_detector_state();
            point_ctr = {1'b0, offset_cfg};
        end
        // apart from a restart, samples of channels beyond the active count leave no trace
        if (ch >= nch) return 1'b0;
        ev.hdr.event_chan = ch;
        if (mode_cfg) begin
            p1   = hist_older[ch];
            p2   = hist_prev[ch];
            p3   = smp;
            full = hist_fill[ch] >= 2;
            hist_older[ch] = hist_prev[ch];
            hist_prev[ch]  = smp;
            if (hist_fill[ch] < 2) hist_fill[ch]++;
            if (refr_left[ch] > 0) begin
                refr_left[ch]--;
            end else if (full) begin
                // first point of a flat top or bottom counts
                if (p2 >= thr_cfg && p1 < p2 && p3 <= p2) begin
                    hit = 1'b1;
                    ev.hdr.direction = DIR_RISE;
                end else if (p2 <= -thr_cfg && p1 > p2 && p3 >= p2) begin
                    hit = 1'b1;
                    ev.hdr.direction = DIR_FALL;
                end
                if (hit) begin
                    ev.hdr.position = point_ctr - 1;
                    ev.level        = p2[SAMPLE_BITS-1:0];
                    refr_left[ch]   = refr_cfg;
                end
            end
        end else begin
            sg = (int'(smp) - thr_cfg >= 0) ? SIGN_ABOVE : SIGN_BELOW;
            if (chan_sign[ch] == SIGN_UNKNOWN || refr_left[ch] > 0) begin
                if (refr_left[ch] > 0) refr_left[ch]--;
            end else if (sg != chan_sign[ch]) begin
                hit = 1'b1;
                ev.hdr.direction = (sg == SIGN_ABOVE) ? DIR_RISE : DIR_FALL;
                ev.hdr.position  = point_ctr;
                ev.level         = smp;
                refr_left[ch]    = refr_cfg;
            end
            chan_sign[ch] = sg;
        end
        if (ch == nch - 1) point_ctr++;
        return hit;
    endfunction

    // mostly no gap, some short, a few long
    function automatic int pick_gap(input bit on);
        int r;
        if (!on) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // samples cluster around the active level, with extremes and full-range noise
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        int r, base, v;
        r    = $urandom_range(0, 99);
        base = (mode_cfg && $urandom_range(0, 1) == 1) ? -thr_cfg : thr_cfg;
        if (r < 60) v = base + int'($urandom_range(0, 600)) - 300;
        else if (r < 80) v = int'($urandom_range(0, 65535)) - 32768;
        else if (r < 90) v = 32767;
        else v = -32768;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic void add_row(input t_row_kind kind, input int a, input int b,
                                    input logic rs = 1'b0, input logic [POS_W-1:0] pos = '0,
                                    input logic dir = DIR_RISE, input int lvl = 0);
        t_stim_row row;
        row.kind = kind;
        row.a    = a;
        row.b    = b;
        row.rs   = rs;
        row.ev.hdr.event_chan = a[CHAN_W-1:0];
        row.ev.hdr.position   = pos;
        row.ev.hdr.direction  = dir;
        row.ev.level          = lvl[SAMPLE_BITS-1:0];
        directed.push_back(row);
    endfunction

    function automatic void check_field(input string field, input logic [POS_W-1:0] want,
                                        input logic [POS_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
            fail_count++;
        end
    endfunction

    // one sample transfer, with a random gap ahead of it
    task automatic send_sample(input logic [CHAN_W-1:0] ch,
                               input logic signed [SAMPLE_BITS-1:0] smp, input logic rs,
                               input t_row_kind kind, input t_det_event typed);
        int         gap;
        bit         hit;
        t_det_event ev;
        gap = pick_gap(tx_idle);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.chan    <= ch;
        in_ch.sample  <= smp;
        in_ch.restart <= rs;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        hit = detect_event(ch, smp, rs, ev);
        if (kind == ROW_EVENT) expected_events.push_back(typed);
        else if (kind == ROW_PREDICTED && hit) expected_events.push_back(ev);
    endtask

    // hold off the sender until every expected event is out and the pipe is empty
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_THRESHOLD:       thr_cfg = int'($signed(data[THR_W-1:0]));
            CFG_EXTREMA_MODE:    mode_cfg = data[0];
            CFG_REFRACTORY:      refr_cfg = int'(data[REFR_W-1:0]);
            CFG_POINT_OFFSET:    offset_cfg = data[OFFSET_W-1:0];
            CFG_ACTIVE_CHANNELS: active_cfg = data[ACTIVE_W-1:0];
            default: ;
        endcase
    endtask

    // event sink: random back-pressure and in-order check
    initial begin : event_sink
        int         hold;
        t_det_event want;
        hold = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected event, chan %0d position 0x%0h dir %0d level %0d",
                             $time, out_ch.event_chan, out_ch.position, out_ch.direction,
                             out_ch.level);
                    fail_count++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_chan", POS_W'(want.hdr.event_chan),
                                POS_W'(out_ch.event_chan));
                    check_field("position", want.hdr.position, out_ch.position);
                    check_field("direction", POS_W'(want.hdr.direction),
                                POS_W'(out_ch.direction));
                    check_field("level", POS_W'(want.level), POS_W'(out_ch.level));
                end
            end
            if (hold > 0) begin
                hold--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                hold = pick_gap(rx_idle);
            end
        end
    end

    // run limit
    initial begin
        while (cycles_run < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles_run++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    // stimulus
    initial begin
        int                            sent, cursor, nch, thr, refr, act;
        bit                            mode;
        logic [OFFSET_W-1:0]           offs;
        logic [CHAN_W-1:0]             ch;
        logic                          rs;
        logic signed [SAMPLE_BITS-1:0] smp;

        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.chan    <= '0;
        in_ch.sample  <= '0;
        in_ch.restart <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_idx       <= CFG_THRESHOLD;
        cfg_data      <= '0;

        thr_cfg    = 0;
        mode_cfg   = 1'b0;
        refr_cfg   = 0;
        offset_cfg = '0;
        active_cfg = 5'd1;
        point_ctr  = '0;
        clear_detector_state();

        // crossings at reset settings: one channel, level zero
        add_row(ROW_QUIET, 0, 100);
        add_row(ROW_EVENT, 0, -100, 1'b0, 32'd1, DIR_FALL, -100);
        add_row(ROW_EVENT, 0, 32767, 1'b0, 32'd2, DIR_RISE, 32767);
        add_row(ROW_EVENT, 0, -32768, 1'b0, 32'd3, DIR_FALL, -32768);
        add_row(ROW_EVENT, 0, 0, 1'b0, 32'd4, DIR_RISE, 0);
        add_row(ROW_QUIET, 15, 5);
        add_row(ROW_QUIET, 0, 7, 1'b1);
        // crossings with refractory count and four channels
        add_row(ROW_WRITE, CFG_THRESHOLD, 1000);
        add_row(ROW_WRITE, CFG_REFRACTORY, 2);
        add_row(ROW_WRITE, CFG_POINT_OFFSET, 100);
        add_row(ROW_WRITE, CFG_ACTIVE_CHANNELS, 4);
        add_row(ROW_PREDICTED, 0, 0, 1'b1);
        add_row(ROW_PREDICTED, 1, 2000);
        add_row(ROW_PREDICTED, 3, 0);
        add_row(ROW_PREDICTED, 0, 1500);
        add_row(ROW_PREDICTED, 0, 0);
        add_row(ROW_PREDICTED, 0, 1500);
        add_row(ROW_PREDICTED, 0, -1);
        // extrema, plateaus, channel count zero
        add_row(ROW_WRITE, CFG_EXTREMA_MODE, 1);
        add_row(ROW_WRITE, CFG_THRESHOLD, 100);
        add_row(ROW_WRITE, CFG_REFRACTORY, 0);
        add_row(ROW_WRITE, CFG_ACTIVE_CHANNELS, 0);
        add_row(ROW_PREDICTED, 0, 0, 1'b1);
        add_row(ROW_PREDICTED, 0, 200);
        add_row(ROW_PREDICTED, 0, 50);
        add_row(ROW_PREDICTED, 0, -300);
        add_row(ROW_PREDICTED, 0, -300);
        add_row(ROW_PREDICTED, 0, 400);
        add_row(ROW_PREDICTED, 0, 400);
        // channel count above the maximum, extreme level, refractory and offset
        add_row(ROW_WRITE, CFG_ACTIVE_CHANNELS, 31);
        add_row(ROW_WRITE, CFG_THRESHOLD, 16'h8001);
        add_row(ROW_WRITE, CFG_REFRACTORY, 65535);
        add_row(ROW_WRITE, CFG_POINT_OFFSET, 32'h7FFF_FFFF);
        add_row(ROW_PREDICTED, 15, 0, 1'b1);
        add_row(ROW_PREDICTED, 15, 5);
        add_row(ROW_PREDICTED, 15, 1);
        add_row(ROW_PREDICTED, 15, 32767);
        add_row(ROW_PREDICTED, 15, -32768);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed[i]) begin
            if (directed[i].kind == ROW_WRITE) begin
                settle();
                write_reg(t_cfg_idx'(directed[i].a), directed[i].b[CFG_DATA_W-1:0]);
            end else begin
                send_sample(directed[i].a[CHAN_W-1:0], directed[i].b[SAMPLE_BITS-1:0],
                            directed[i].rs, directed[i].kind, directed[i].ev);
            end
        end

        // random phases, each with its own register setting
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            case (phase)
                0: begin
                    thr = 32767;  mode = 1'b0; refr = 0;     offs = '0;            act = 16;
                end
                1: begin
                    thr = -32767; mode = 1'b1; refr = 1;     offs = 31'h7FFF_FFFF; act = 3;
                end
                2: begin
                    thr = 32767;  mode = 1'b1; refr = 65535; offs = 31'd5;         act = 0;
                end
                3: begin
                    thr = -32767; mode = 1'b0; refr = 0;     offs = 31'h7FFF_FFF0; act = 31;
                end
                default: begin
                    if ($urandom_range(0, 9) == 0) thr = int'($urandom_range(0, 65534)) - 32767;
                    else thr = int'($urandom_range(0, 4000)) - 2000;
                    mode = 1'($urandom_range(0, 1));
                    refr = $urandom_range(0, 3);
                    offs = OFFSET_W'($urandom);
                    act  = $urandom_range(1, 16);
                end
            endcase
            write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr & 32'hFFFF));
            write_reg(CFG_EXTREMA_MODE, CFG_DATA_W'(mode));
            write_reg(CFG_REFRACTORY, CFG_DATA_W'(refr));
            write_reg(CFG_POINT_OFFSET, offs);
            write_reg(CFG_ACTIVE_CHANNELS, CFG_DATA_W'(act));
            tx_idle = (phase != 0) && ($urandom_range(0, 3) != 0);
            rx_idle = (phase != 0) && ($urandom_range(0, 3) != 0);
            nch     = live_channels();
            cursor  = 0;
            sent    = 0;
            // channels mostly in order, now and then a stray tag or a restart
            while (sent < PHASE_ITEMS) begin
                rs = (sent == 0) || ($urandom_range(0, 99) == 0);
                if (rs) cursor = 0;
                if ($urandom_range(0, 19) == 0) begin
                    ch = CHAN_W'($urandom_range(0, CHANNELS - 1));
                end else begin
                    ch     = cursor[CHAN_W-1:0];
                    cursor = (cursor + 1) % nch;
                end
                smp = pick_sample();
                send_sample(ch, smp, rs, ROW_PREDICTED, '0);
                if (ch < nch) sent++;
            end
        end

        settle();
        rx_idle = 1'b0;
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && expected_events.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
